>>> src/tcpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpt_pkg
// shared types and constants of the three-channel programmable timer
// ----------------------------------------------------------------------------
package tcpt_pkg;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_GATE  = 2'd3
	} tcpt_action_t;

	// bus offsets with a meaning of their own
	localparam logic [2:0] OFF_CTRL_SHARED = 3'd0;
	localparam logic [2:0] OFF_CTRL1_STAT  = 3'd1;

	// control register bit positions
	localparam int CB_SPECIAL  = 0; // t0 internal reset, t1 offset-0 select, t2 prescaler
	localparam int CB_INTCLK   = 1;
	localparam int CB_DUAL     = 2;
	localparam int CB_GATEMODE = 3;
	localparam int CB_LATCHLD  = 4;
	localparam int CB_IRQEN    = 6;
	localparam int CB_OUTEN    = 7;

	localparam int          NUM_TIMERS   = 3;
	localparam logic [7:0]  CTRL0_RESET  = 8'h01;
	localparam logic [15:0] LATCH_RESET  = 16'hffff;
	localparam logic [2:0]  PRESCALE_TOP = 3'd7;

	typedef struct packed {
		tcpt_action_t action;
		logic [2:0]   reg_offset;
		logic [7:0]   write_data;
		logic         internal_tick;
		logic [2:0]   external_ticks;
		logic [2:0]   gate_levels;
	} tcpt_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
		logic [2:0] timer_outputs;
	} tcpt_result_t;

endpackage
`default_nettype wire

>>> src/tcpt_count.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpt_count
// one count step of a timer counter in 16-bit or dual 8-bit mode
// ----------------------------------------------------------------------------
module tcpt_count (
	input  wire logic [15:0] count,
	input  wire logic [15:0] latch,
	input  wire logic        dual,
	output logic [15:0]      count_next,
	output logic             expired
);

	logic [7:0] lo;
	logic [7:0] hi;

	assign lo = count[7:0];
	assign hi = count[15:8];

	always_comb begin
		expired    = 1'b0;
		count_next = count;
		if (dual) begin
			if (lo == 8'd0) begin
				if (hi == 8'd0) expired = 1'b1;
				else count_next = {hi - 8'd1, latch[7:0]};
			end else begin
				count_next = {hi, lo - 8'd1};
			end
		end else begin
			if (count == 16'd0) expired = 1'b1;
			else count_next = count - 16'd1;
		end
		// timeout reloads from the latch
		if (expired) count_next = latch;
	end

endmodule
`default_nettype wire

>>> src/tcpt_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpt_core
// timer register file and the single-pass update for one item
// ----------------------------------------------------------------------------
module tcpt_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step_en,
	input  wire tcpt_pkg::tcpt_item_t item,
	output tcpt_pkg::tcpt_result_t res
);

	logic [2:0][7:0]  ctrl_q, ctrl_d;
	logic [2:0][15:0] latch_q, latch_d;
	logic [2:0][15:0] count_q, count_d;
	logic [2:0][7:0]  cap_q, cap_d;
	logic [7:0]       msb_q, msb_d;
	logic [2:0]       flags_q, flags_d;
	logic [2:0]       outlv_q, outlv_d;
	logic [2:0]       gates_q, gates_d;
	logic [2:0]       presc_q, presc_d;

	logic [2:0][15:0] cnt_next;
	logic [2:0]       cnt_exp;

	for (genvar g = 0; g < tcpt_pkg::NUM_TIMERS; g++) begin : g_cnt
		tcpt_count u_count (
			.count      (count_q[g]),
			.latch      (latch_q[g]),
			.dual       (ctrl_q[g][tcpt_pkg::CB_DUAL]),
			.count_next (cnt_next[g]),
			.expired    (cnt_exp[g])
		);
	end

	always_comb begin
		logic [1:0] tsel;
		logic [7:0] diffs;
		logic       tclk;
		logic       do_count;
		logic       irq_now;
		logic       irq_new;

		ctrl_d  = ctrl_q;
		latch_d = latch_q;
		count_d = count_q;
		cap_d   = cap_q;
		msb_d   = msb_q;
		flags_d = flags_q;
		outlv_d = outlv_q;
		gates_d = gates_q;
		presc_d = presc_q;
		res.read_data = 8'd0;
		tsel     = 2'(item.reg_offset[2:1] - 2'd1);
		diffs    = 8'd0;
		tclk     = 1'b0;
		do_count = 1'b0;

		irq_now = 1'b0;
		for (int t = 0; t < 3; t++)
			if (flags_q[t] && ctrl_q[t][tcpt_pkg::CB_IRQEN]) irq_now = 1'b1;

		case (item.action)
			tcpt_pkg::ACT_READ: begin
				if (item.reg_offset == tcpt_pkg::OFF_CTRL_SHARED) begin
					res.read_data = 8'd0;
				end else if (item.reg_offset == tcpt_pkg::OFF_CTRL1_STAT) begin
					res.read_data = {irq_now, 4'd0, flags_q};
				end else if (!item.reg_offset[0]) begin
					// counter high byte, low byte captured for the next read
					cap_d[tsel]   = count_q[tsel][7:0];
					res.read_data = count_q[tsel][15:8];
				end else begin
					res.read_data = cap_q[tsel];
				end
			end
			tcpt_pkg::ACT_WRITE: begin
				if (item.reg_offset[2:1] == 2'd0) begin
					if (item.reg_offset == tcpt_pkg::OFF_CTRL1_STAT) tsel = 2'd1;
					else if (ctrl_q[1][tcpt_pkg::CB_SPECIAL]) tsel = 2'd0;
					else tsel = 2'd2;
					diffs = item.write_data ^ ctrl_q[tsel];
					ctrl_d[tsel] = item.write_data;
					if (!item.write_data[tcpt_pkg::CB_OUTEN]) outlv_d[tsel] = 1'b0;
					if (tsel == 2'd0 && diffs[tcpt_pkg::CB_SPECIAL]) begin
						if (!item.write_data[tcpt_pkg::CB_SPECIAL]) begin
							count_d = latch_q;
							presc_d = 3'd0;
						end
						flags_d = 3'd0;
						if (diffs[tcpt_pkg::CB_INTCLK]) count_d[0] = latch_q[0];
					end
				end else if (!item.reg_offset[0]) begin
					flags_d[tsel] = 1'b0;
					msb_d         = item.write_data;
				end else begin
					latch_d[tsel] = {msb_q, item.write_data};
					flags_d[tsel] = 1'b0;
					if (!ctrl_q[tsel][tcpt_pkg::CB_LATCHLD]) begin
						count_d[tsel] = {msb_q, item.write_data};
						if (tsel == 2'd2) presc_d = 3'd0;
					end
				end
			end
			tcpt_pkg::ACT_TICK: begin
				if (!ctrl_q[0][tcpt_pkg::CB_SPECIAL]) begin
					for (int t = 0; t < 3; t++) begin
						tclk = ctrl_q[t][tcpt_pkg::CB_INTCLK] ? item.internal_tick
							: item.external_ticks[t];
						do_count = tclk;
						if (tclk && t == 2 && ctrl_q[2][tcpt_pkg::CB_SPECIAL]) begin
							// divide-by-8: one count when the prescaler wraps
							if (presc_q == tcpt_pkg::PRESCALE_TOP) begin
								presc_d = 3'd0;
							end else begin
								presc_d  = presc_q + 3'd1;
								do_count = 1'b0;
							end
						end
						if (do_count) begin
							count_d[t] = cnt_next[t];
							if (cnt_exp[t]) begin
								if (ctrl_q[t][tcpt_pkg::CB_IRQEN]) flags_d[t] = 1'b1;
								if (ctrl_q[t][tcpt_pkg::CB_OUTEN]) outlv_d[t] = ~outlv_q[t];
							end
						end
					end
				end
			end
			tcpt_pkg::ACT_GATE: begin
				for (int t = 0; t < 3; t++) begin
					if (gates_q[t] && !item.gate_levels[t]
						&& !ctrl_q[t][tcpt_pkg::CB_GATEMODE]) begin
						count_d[t] = latch_q[t];
						if (t == 2) presc_d = 3'd0;
					end
				end
				gates_d = item.gate_levels;
			end
			default: begin
				res.read_data = 8'd0;
			end
		endcase

		irq_new = 1'b0;
		for (int t = 0; t < 3; t++) begin
			if (flags_d[t] && ctrl_d[t][tcpt_pkg::CB_IRQEN]) irq_new = 1'b1;
			res.timer_outputs[t] = outlv_d[t] & ctrl_d[t][tcpt_pkg::CB_OUTEN];
		end
		res.irq = irq_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q  <= {8'd0, 8'd0, tcpt_pkg::CTRL0_RESET};
			latch_q <= {3{tcpt_pkg::LATCH_RESET}};
			count_q <= {3{tcpt_pkg::LATCH_RESET}};
			cap_q   <= '0;
			msb_q   <= 8'd0;
			flags_q <= 3'd0;
			outlv_q <= 3'd0;
			gates_q <= 3'd0;
			presc_q <= 3'd0;
		end else if (step_en) begin
			ctrl_q  <= ctrl_d;
			latch_q <= latch_d;
			count_q <= count_d;
			cap_q   <= cap_d;
			msb_q   <= msb_d;
			flags_q <= flags_d;
			outlv_q <= outlv_d;
			gates_q <= gates_d;
			presc_q <= presc_d;
		end
	end

	// timer ticks move neither counters nor prescaler while the internal reset bit is held
	a_hold_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && item.action == tcpt_pkg::ACT_TICK && ctrl_q[0][tcpt_pkg::CB_SPECIAL]
		|=> $stable(count_q) && $stable(presc_q))
		else $error("counter moved while internal reset held");

	// a bus read never changes flags, controls or counters
	a_read_harmless: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && item.action == tcpt_pkg::ACT_READ
		|=> $stable(flags_q) && $stable(ctrl_q) && $stable(count_q))
		else $error("bus read altered timer state");

	// a gate update leaves flags and controls alone
	a_gate_flags: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && item.action == tcpt_pkg::ACT_GATE
		|=> $stable(flags_q) && $stable(ctrl_q))
		else $error("gate update altered flags or controls");

endmodule
`default_nettype wire

>>> src/three_channel_programmable_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_channel_programmable_timer
// three 16-bit down counters with bus registers, gate reload and irq
// ----------------------------------------------------------------------------
// usage:
//  - input channel (in_valid/in_ready) carries one item per bus read, bus
//    write, timer clock tick or gate level update, selected by action
//  - output channel (out_valid/out_ready) returns exactly one item per input
//    item: read_data (zero unless a bus read), irq and the timer output pins
//    as they stand after that item
//  - the item is captured in the input register, then the timer state is
//    updated and the result registered once the result register is free
//  - throughput is one item per cycle unless stalled; a single combinational
//    pass over the timer registers between input and result sets this
//  - when the receiver stalls the result register holds; the input register
//    still takes one more item, after which in_ready drops until out_ready
//  - reset (arst_n low) clears both valid bits, sets control 0x01 on timer 0
//    (internal reset held) and 0x00 on the others, latches and counters
//    0xffff, all flags, outputs, gates and the prescaler cleared
// ----------------------------------------------------------------------------
module three_channel_programmable_timer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] action,
	input  wire logic [2:0] reg_offset,
	input  wire logic [7:0] write_data,
	input  wire logic       internal_tick,
	input  wire logic [2:0] external_ticks,
	input  wire logic [2:0] gate_levels,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      read_data,
	output logic            irq,
	output logic [2:0]      timer_outputs
);

	// input register
	logic                   valid_s1;
	tcpt_pkg::tcpt_item_t   item_s1;
	// result register
	logic                   valid_s2;
	tcpt_pkg::tcpt_result_t res_s2;
	tcpt_pkg::tcpt_result_t res_next;

	logic advance;

	// item moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action         <= tcpt_pkg::tcpt_action_t'(action);
			item_s1.reg_offset     <= reg_offset;
			item_s1.write_data     <= write_data;
			item_s1.internal_tick  <= internal_tick;
			item_s1.external_ticks <= external_ticks;
			item_s1.gate_levels    <= gate_levels;
		end
	end

	tcpt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.res     (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res_next;
	end

	assign out_valid     = valid_s2;
	assign read_data     = res_s2.read_data;
	assign irq           = res_s2.irq;
	assign timer_outputs = res_s2.timer_outputs;

	// back-pressure only when both registers are full and the receiver stalls
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled without a full pipeline");

	// every advanced item shows up as a result
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result lost after advance");

	// a waiting item stays in the input register
	a_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("pending item dropped");

endmodule
`default_nettype wire
